### sv/assoc_cache_lru_stamp_defines.svh
// assertion helpers used by the checker file
`ifndef ASSOC_CACHE_LRU_STAMP_DEFINES_SVH
`define ASSOC_CACHE_LRU_STAMP_DEFINES_SVH

// same-cycle implication, off during reset
`define ACLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ACLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/acls_pkg.sv
`default_nettype none
package acls_pkg;

  localparam int TYPE_W    = 32;
  localparam int CREATOR_W = 32;
  localparam int IDENT_W   = 16;
  localparam int FILL_W    = 32;
  localparam int SLOT_W    = 5;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic match;
    logic encode;
    logic scan_init;
    logic scan_step;
    logic write_line;
    logic touch;
    logic out_load;
  } acls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic hit_any;
    logic free_any;
    logic scan_last;
  } acls_status_t;

endpackage
`default_nettype wire

### sv/acls_if.sv
`default_nettype none
interface acls_req_if;
  import acls_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [TYPE_W-1:0]           type_code;
  logic [CREATOR_W-1:0]        creator_code;
  logic signed [IDENT_W-1:0]   resource_id;
  logic [FILL_W-1:0]           fill_data;

  modport source (output valid, op, type_code, creator_code, resource_id, fill_data,
                  input ready);
  modport sink (input valid, op, type_code, creator_code, resource_id, fill_data,
                output ready);
endinterface

interface acls_rsp_if;
  import acls_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic [FILL_W-1:0] read_data;
  logic              evicted;

  modport source (output valid, hit, slot, read_data, evicted, input ready);
  modport sink (input valid, hit, slot, read_data, evicted, output ready);
endinterface
`default_nettype wire

### sv/acls_ram.sv
`default_nettype none
module acls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/acls_ctrl.sv
`default_nettype none
module acls_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output acls_pkg::acls_cmd_t         cmd,
  input  wire acls_pkg::acls_status_t stat
);
  import acls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_ENCODE,
    S_DECIDE,
    S_SCAN,
    S_SCAN_END,
    S_WRITE,
    S_TOUCH,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_ENCODE;
      end
      S_ENCODE: begin
        cmd.encode = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.op == OP_LOOKUP) begin
          state_next = stat.hit_any ? S_TOUCH : S_FINISH;
        end else if (stat.free_any) begin
          state_next = S_WRITE;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      // last stamp compare lands here
      S_SCAN_END: state_next = S_WRITE;
      S_WRITE: begin
        cmd.write_line = 1'b1;
        state_next     = S_FINISH;
      end
      S_TOUCH: begin
        cmd.touch  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = (out_valid && !out_ready) || cmd.out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

### sv/acls_dp.sv
`default_nettype none
module acls_dp #(
  parameter int ENTRIES      = 32,
  parameter int STAMP_BITS   = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire acls_pkg::acls_cmd_t                     cmd,
  output acls_pkg::acls_status_t                       stat,
  input  wire logic                                    op,
  input  wire logic [acls_pkg::TYPE_W-1:0]             type_code,
  input  wire logic [acls_pkg::CREATOR_W-1:0]          creator_code,
  input  wire logic signed [acls_pkg::IDENT_W-1:0]     resource_id,
  input  wire logic [acls_pkg::FILL_W-1:0]             fill_data,
  output logic                                         hit,
  output logic [acls_pkg::SLOT_W-1:0]                  slot,
  output logic [acls_pkg::FILL_W-1:0]                  read_data,
  output logic                                         evicted
);
  import acls_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  // latched item
  logic                    op_q;
  logic [TYPE_W-1:0]       type_q;
  logic [CREATOR_W-1:0]    creator_q;
  logic [IDENT_W-1:0]      ident_q;
  logic [PAYLOAD_BITS-1:0] data_q;

  // key store, compared in parallel
  logic [ENTRIES-1:0]   line_valid;
  logic [TYPE_W-1:0]    line_type    [ENTRIES];
  logic [CREATOR_W-1:0] line_creator [ENTRIES];
  logic [IDENT_W-1:0]   line_ident   [ENTRIES];

  logic [ENTRIES-1:0] match_comb, match_vec;
  logic               hit_any_c, free_any_c;
  logic [IDX_W-1:0]   hit_idx_c, free_idx_c;
  logic               hit_any, free_any;
  logic [IDX_W-1:0]   hit_idx, free_idx;

  // stamp scan
  logic [STAMP_BITS-1:0] count;
  logic [STAMP_BITS-1:0] stamp_next;
  logic [STAMP_BITS-1:0] least;
  logic [STAMP_BITS-1:0] stamp_rd;
  logic [IDX_W-1:0]      scan_addr;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  cmp_pending;
  logic [IDX_W-1:0]      victim;
  logic [IDX_W-1:0]      write_idx;

  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic                    stamp_we;
  logic [IDX_W-1:0]        stamp_waddr;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_comb[i] = line_valid[i] && (line_type[i] == type_q) &&
                      (line_creator[i] == creator_q) && (line_ident[i] == ident_q);
    end
  end

  // lowest-numbered match and lowest-numbered free line
  always_comb begin
    hit_any_c  = 1'b0;
    hit_idx_c  = '0;
    free_any_c = 1'b0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_any_c = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!line_valid[i]) begin
        free_any_c = 1'b1;
        free_idx_c = IDX_W'(i);
      end
    end
  end

  assign write_idx      = free_any ? free_idx : victim;
  assign stamp_next     = count + STAMP_BITS'(1);
  assign stamp_we       = cmd.write_line || cmd.touch;
  assign stamp_waddr    = cmd.write_line ? write_idx : hit_idx;
  assign stat.op        = op_q;
  assign stat.hit_any   = hit_any;
  assign stat.free_any  = free_any;
  assign stat.scan_last = (scan_addr == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op;
      type_q    <= type_code;
      creator_q <= creator_code;
      ident_q   <= resource_id;
      data_q    <= PAYLOAD_BITS'(fill_data);
    end
    if (cmd.match) begin
      match_vec <= match_comb;
    end
    if (cmd.encode) begin
      hit_any  <= hit_any_c;
      hit_idx  <= hit_idx_c;
      free_any <= free_any_c;
      free_idx <= free_idx_c;
    end
    if (cmd.scan_init) begin
      scan_addr <= '0;
      least     <= count;
      victim    <= '0;
    end
    if (cmd.scan_step) begin
      scan_addr <= scan_addr + IDX_W'(1);
      cmp_idx   <= scan_addr;
    end
    // strictly below keeps the first line on ties
    if (cmp_pending && (stamp_rd < least)) begin
      least  <= stamp_rd;
      victim <= cmp_idx;
    end
    if (cmd.write_line) begin
      line_type[write_idx]    <= type_q;
      line_creator[write_idx] <= creator_q;
      line_ident[write_idx]   <= ident_q;
    end
    if (cmd.out_load) begin
      if (op_q == OP_LOOKUP) begin
        hit       <= hit_any;
        slot      <= hit_any ? SLOT_W'(hit_idx) : '0;
        read_data <= hit_any ? FILL_W'(pay_rd) : '0;
        evicted   <= 1'b0;
      end else begin
        hit       <= 1'b0;
        slot      <= SLOT_W'(write_idx);
        read_data <= '0;
        evicted   <= !free_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid  <= '0;
      count       <= '0;
      cmp_pending <= 1'b0;
    end else begin
      cmp_pending <= cmd.scan_step;
      if (cmd.write_line) begin
        line_valid[write_idx] <= 1'b1;
      end
      if (stamp_we) begin
        count <= stamp_next;
      end
    end
  end

  acls_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (stamp_next),
    .re    (cmd.scan_step),
    .raddr (scan_addr),
    .rdata (stamp_rd)
  );

  acls_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (ENTRIES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (cmd.write_line),
    .waddr (write_idx),
    .wdata (data_q),
    .re    (cmd.touch),
    .raddr (hit_idx),
    .rdata (pay_rd)
  );

endmodule
`default_nettype wire

### sv/assoc_cache_lru_stamp.sv
// Fully associative cache of ENTRIES lines keyed by type code, creator code
// and resource id, with least-recently-used replacement by access stamp. One
// request in, one response out on each channel. Every request passes the
// match, encode and decide states; a lookup that hits then touches its line
// to read its data and renew its stamp, and an insert writes a free line or,
// in a full cache, the victim found by a search that reads the stamp memory
// one line per cycle. Key compare and first-match selection are each one
// registered step over all lines. A new request is taken as soon as the
// previous one has reached the response register, even if that response
// has not been transferred yet; the next response then waits in its last step
// until the response register is free.
`default_nettype none
module assoc_cache_lru_stamp #(
  parameter int ENTRIES      = 32,
  parameter int STAMP_BITS   = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  acls_req_if.sink    req,
  acls_rsp_if.source  rsp
);
  import acls_pkg::*;

  acls_cmd_t    cmd;
  acls_status_t stat;

  acls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  acls_dp #(
    .ENTRIES      (ENTRIES),
    .STAMP_BITS   (STAMP_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (req.op),
    .type_code    (req.type_code),
    .creator_code (req.creator_code),
    .resource_id  (req.resource_id),
    .fill_data    (req.fill_data),
    .hit          (rsp.hit),
    .slot         (rsp.slot),
    .read_data    (rsp.read_data),
    .evicted      (rsp.evicted)
  );

endmodule
`default_nettype wire

### sv/acls_checker.sv
`default_nettype none
`include "assoc_cache_lru_stamp_defines.svh"
module acls_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_hit,
  input wire logic [4:0]  rsp_slot,
  input wire logic [31:0] rsp_read_data,
  input wire logic        rsp_evicted
);

  logic [1:0]  pend;
  logic [38:0] rsp_bundle;
  logic        req_fire, rsp_fire;

  assign req_fire   = req_valid && req_ready;
  assign rsp_fire   = rsp_valid && rsp_ready;
  assign rsp_bundle = {rsp_hit, rsp_slot, rsp_read_data, rsp_evicted};

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  `ACLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bundle), "response changed while stalled")
  `ACLS_ASSERT_NOW(a_hit_no_evict, rsp_valid, !(rsp_hit && rsp_evicted), "hit and evicted together")
  `ACLS_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_hit, rsp_read_data == 32'd0, "data on a non-hit")
  `ACLS_ASSERT_NOW(a_rsp_has_req, rsp_valid, pend != 2'd0, "response with no request")
  `ACLS_ASSERT_NOW(a_accept_room, req_fire, pend != 2'd2, "request taken with two in flight")

endmodule

bind assoc_cache_lru_stamp acls_checker u_acls_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_hit       (rsp.hit),
  .rsp_slot      (rsp.slot),
  .rsp_read_data (rsp.read_data),
  .rsp_evicted   (rsp.evicted)
);
`default_nettype wire
